/* hw/rtl/fust_pkg.sv */
package fust_pkg;

    // alphabet size and derived widths
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int IDX_W        = $clog2(SYMBOL_COUNT);
    localparam int PTR_W        = IDX_W + 1;
    localparam int CNT_W        = 2;

    // saturating occurrence count codes
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONCE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request, clear stream if flagged
        logic update;    // count the symbol, enqueue on first sight
        logic head_rd;   // read queue entry at head
        logic cnt_rd;    // read count of the head symbol
        logic pop;       // drop the head entry
        logic finish;    // load the result registers
    } fust_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic queue_empty;
        logic head_repeated;
    } fust_status_t;

endpackage

/* hw/rtl/fust_ctrl.sv */
module fust_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sym_valid,
    output logic                  sym_stall,
    output logic                  res_valid,
    input  logic                  res_stall,
    input  fust_pkg::fust_status_t status,
    output fust_pkg::fust_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_COUNT   = 3'd1;
    localparam logic [2:0] ST_HEAD_RD = 3'd2;
    localparam logic [2:0] ST_CNT_RD  = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       out_free;

    assign sym_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sym_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.update = 1'b1;
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                if (status.queue_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.head_rd = 1'b1;
                    state_next  = ST_CNT_RD;
                end
            end
            ST_CNT_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.head_repeated)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

/* hw/rtl/fust_dp.sv */
module fust_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fust_pkg::SYM_W-1:0]       symbol,
    input  logic                             start_of_stream,
    input  fust_pkg::fust_cmd_t              cmd,
    output fust_pkg::fust_status_t           status,
    output logic                             found,
    output logic [fust_pkg::SYM_W-1:0]       first_unique
);

    // count store and order queue
    logic [fust_pkg::CNT_W-1:0] cnt_mem [fust_pkg::SYMBOL_COUNT];
    logic [fust_pkg::SYM_W-1:0] queue_mem [fust_pkg::SYMBOL_COUNT];

    logic [fust_pkg::SYMBOL_COUNT-1:0] seen_valid_reg;
    logic [fust_pkg::SYM_W-1:0]        sym_reg;
    logic [fust_pkg::PTR_W-1:0]        head_reg;
    logic [fust_pkg::PTR_W-1:0]        tail_reg;
    logic [fust_pkg::CNT_W-1:0]        cnt_rdata_reg;
    logic [fust_pkg::IDX_W-1:0]        cnt_idx_reg;
    logic [fust_pkg::SYM_W-1:0]        q_rdata_reg;
    logic                              found_reg;
    logic [fust_pkg::SYM_W-1:0]        first_unique_reg;

    logic                              cnt_rd_en;
    logic [fust_pkg::IDX_W-1:0]        cnt_raddr;
    logic [fust_pkg::CNT_W-1:0]        count_cur;
    logic [fust_pkg::IDX_W-1:0]        sym_idx;
    logic                              in_range;
    logic                              first_sight;
    logic                              queue_full;

    assign sym_idx     = sym_reg[fust_pkg::IDX_W-1:0];
    assign in_range    = {1'b0, sym_reg} < fust_pkg::PTR_W'(fust_pkg::SYMBOL_COUNT);
    assign count_cur   = seen_valid_reg[cnt_idx_reg] ? cnt_rdata_reg : fust_pkg::CNT_NONE;
    assign first_sight = (count_cur == fust_pkg::CNT_NONE);
    assign queue_full  = (tail_reg == fust_pkg::PTR_W'(fust_pkg::SYMBOL_COUNT));

    assign cnt_rd_en = cmd.load || cmd.cnt_rd;
    assign cnt_raddr = cmd.load ? symbol[fust_pkg::IDX_W-1:0]
                                : q_rdata_reg[fust_pkg::IDX_W-1:0];

    assign status.queue_empty   = (head_reg == tail_reg);
    assign status.head_repeated = (count_cur == fust_pkg::CNT_MANY);

    assign found        = found_reg;
    assign first_unique = first_unique_reg;

    // count store: one read, one write
    always_ff @(posedge clk)
    begin
        if (cnt_rd_en)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
            cnt_idx_reg   <= cnt_raddr;
        end
        if (cmd.update && in_range)
        begin
            cnt_mem[sym_idx] <= first_sight ? fust_pkg::CNT_ONCE : fust_pkg::CNT_MANY;
        end
    end

    // order queue: one read, one write
    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
        begin
            q_rdata_reg <= queue_mem[head_reg[fust_pkg::IDX_W-1:0]];
        end
        if (cmd.update && in_range && first_sight && !queue_full)
        begin
            queue_mem[tail_reg[fust_pkg::IDX_W-1:0]] <= sym_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg <= symbol;
        end
        if (cmd.finish)
        begin
            found_reg        <= !status.queue_empty;
            first_unique_reg <= status.queue_empty ? '0 : q_rdata_reg;
        end
    end

    // seen flags and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_valid_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
        end
        else
        begin
            if (cmd.load && start_of_stream)
            begin
                seen_valid_reg <= '0;
                head_reg       <= '0;
                tail_reg       <= '0;
            end
            if (cmd.update && in_range)
            begin
                seen_valid_reg[sym_idx] <= 1'b1;
                if (first_sight && !queue_full)
                begin
                    tail_reg <= tail_reg + fust_pkg::PTR_W'(1);
                end
            end
            if (cmd.pop)
            begin
                head_reg <= head_reg + fust_pkg::PTR_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= fust_pkg::PTR_W'(fust_pkg::SYMBOL_COUNT))
        else $error("queue tail beyond alphabet size");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && start_of_stream |=> (head_reg == '0) && (tail_reg == '0)
            && (seen_valid_reg == '0))
        else $error("start of stream did not clear state");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.queue_empty)
        else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/first_unique_symbol_tracker.sv */
// first unique symbol tracker: each request carries one byte symbol and a
// start_of_stream flag that clears all counts and the order queue before the
// symbol is taken; every request yields exactly one result giving the oldest
// symbol of the current stream that has occurred exactly once (found = 1) or
// found = 0 with first_unique = 0. one request is worked at a time and the
// input stalls until its result is loaded. after a request is accepted its
// symbol is counted, then each head check takes a registered queue read, a
// registered count read and the compare; repeated entries are dropped from
// the queue head until a unique one is found or the queue ends empty. the
// next request is taken once the result is loaded. dropped entries never
// return, so the entries dropped over a stream are at most the alphabet
// size. the result register frees the input side: the next request is
// accepted while a result still waits for the consumer; a second finished
// result waits in the sequencer until the first is taken. after reset the
// block is ready at once; no clearing pass is needed.
module first_unique_symbol_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sym_valid,
    output logic                          sym_stall,
    input  logic [fust_pkg::SYM_W-1:0]    symbol,
    input  logic                          start_of_stream,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          found,
    output logic [fust_pkg::SYM_W-1:0]    first_unique
);

    // command and status between sequencer and datapath
    fust_pkg::fust_cmd_t    cmd;
    fust_pkg::fust_status_t status;

    // sequencer: accept, count, walk the queue head, hand off the result
    fust_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: count store, order queue, pointers and result registers
    fust_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .symbol          (symbol),
        .start_of_stream (start_of_stream),
        .cmd             (cmd),
        .status          (status),
        .found           (found),
        .first_unique    (first_unique)
    );

endmodule
